// ----- rtl/bdbag_pkg.sv -----
// Shared types and constants of the bounded deque/bag core.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bdbag_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W           = 32;
   localparam int CMD_W            = 3;
   localparam int STATUS_W         = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FETCH,
      ST_FRONT,
      ST_BACK,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/bounded_deque_bag_core.sv -----
// Top level of the bounded deque/bag: command sequencer around the entry store.
// Depends on bdbag_pkg and bdbag_ram.
`timescale 1ns / 1ps
//
//  channel | direction | tdata fields, lowest bit first
//  --------+-----------+------------------------------------------------------------
//  req     | in        | command[2:0], value[34:3], zero pad to 40 bits
//  rsp     | out       | front_value, back_value, item_count, is_empty, found, status
//
// Request sequence: push, pop and unused codes are accepted, then front and back are read
// back from the store, then handed off; the read back is skipped when the store ends up
// empty. Contains scans from the front until a match or the last entry (no scan on an
// empty store); remove then moves each later entry one step toward the front.
// The scan, the gap closing and the front/back read back all go through the single read
// port of the entry RAM, one entry per cycle.
// Reset clears pointers, count and both handshakes; the RAM needs no clearing since an
// entry is read only after a push wrote it. A new request is taken while a finished
// response still waits in the output register.

module bounded_deque_bag_core #(
   parameter int CAPACITY = bdbag_pkg::CAPACITY_DEFAULT,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int RSP_W   = ((2 * bdbag_pkg::DATA_W + CNT_W + 2 + bdbag_pkg::STATUS_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,   // command[2:0], value[34:3]
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // front_value, back_value, item_count, is_empty,
                                         // found, status (lowest first)
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int SUM_W = CNT_W + 1;
   localparam int DW    = bdbag_pkg::DATA_W;
   localparam int CW    = bdbag_pkg::CMD_W;
   localparam int SW    = bdbag_pkg::STATUS_W;

   // physical slot of logical position k from the front
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(k);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   bdbag_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CW-1:0]          cmd_ff, cmd_in;
   logic signed [DW-1:0]   value_ff, value_in;
   logic                   found_ff, found_in;
   logic [SW-1:0]          status_ff, status_in;
   logic signed [DW-1:0]   front_ff, front_in;
   logic signed [DW-1:0]   back_ff, back_in;
   logic [CNT_W-1:0]       scan_k_ff, scan_k_in;   // next position to read
   logic                   cmp_vld_ff, cmp_vld_in; // read data is pending compare
   logic [CNT_W-1:0]       cmp_k_ff, cmp_k_in;     // position of pending read data
   logic [CNT_W-1:0]       sh_k_ff, sh_k_in;       // position being overwritten
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [DW-1:0]          rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DW-1:0]          wr_data;

   logic [CW-1:0]          req_command;
   logic signed [DW-1:0]   req_value;
   logic                   full;
   logic                   empty;
   logic                   match;
   logic                   last;
   logic [IDX_W-1:0]       head_dec;

   bdbag_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .DATA_W (DW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_command = req_tdata[CW-1:0];
   assign req_value   = req_tdata[CW+DW-1:CW];

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign match    = cmp_vld_ff && (rd_data == value_ff);
   assign last     = cmp_vld_ff && (cmp_k_ff == count_ff - 1'b1);

   assign req_tready = (state_ff == bdbag_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdbag_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      front_ff    <= front_in;
      back_ff     <= back_in;
      scan_k_ff   <= scan_k_in;
      cmp_k_ff    <= cmp_k_in;
      sh_k_ff     <= sh_k_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      scan_k_in    = scan_k_ff;
      cmp_vld_in   = 1'b0;
      cmp_k_in     = cmp_k_ff;
      sh_k_in      = sh_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = req_value;

      unique case (state_ff)
         bdbag_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_command;
               value_in  = req_value;
               found_in  = 1'b0;
               status_in = bdbag_pkg::STATUS_OK;
               state_in  = bdbag_pkg::ST_FETCH;
               unique case (req_command) inside
                  bdbag_pkg::CMD_PUSH_FRONT, bdbag_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = bdbag_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_command == bdbag_pkg::CMD_PUSH_FRONT) begin
                           head_in = head_dec;
                           wr_addr = head_dec;
                        end else begin
                           wr_addr = slot_of(head_ff, count_ff);
                        end
                     end
                  end
                  bdbag_pkg::CMD_POP_FRONT, bdbag_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        status_in = bdbag_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_command == bdbag_pkg::CMD_POP_FRONT) begin
                           head_in = slot_of(head_ff, CNT_W'(1));
                        end
                     end
                  end
                  bdbag_pkg::CMD_CONTAINS, bdbag_pkg::CMD_REMOVE: begin
                     if (!empty) begin
                        scan_k_in = '0;
                        state_in  = bdbag_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     // unused codes: no change, plain status
                  end
               endcase
            end
         end

         // one read issued per cycle, compare on the data of the read before
         bdbag_pkg::ST_SCAN: begin
            if (match) begin
               found_in = 1'b1;
               if (cmd_ff == bdbag_pkg::CMD_REMOVE) begin
                  if (cmp_k_ff + 1'b1 < count_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, cmp_k_ff + 1'b1);
                     sh_k_in  = cmp_k_ff;
                     state_in = bdbag_pkg::ST_SHIFT;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = bdbag_pkg::ST_FETCH;
                  end
               end else begin
                  state_in = bdbag_pkg::ST_FETCH;
               end
            end else if (last) begin
               state_in = bdbag_pkg::ST_FETCH;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(head_ff, scan_k_ff);
               scan_k_in  = scan_k_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_k_in   = scan_k_ff;
            end
         end

         // close the gap: entry k+1 moves into k, next read overlaps the write
         bdbag_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, sh_k_ff);
            wr_data = rd_data;
            if (sh_k_ff + 2'd2 < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, sh_k_ff + 2'd2);
               sh_k_in = sh_k_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = bdbag_pkg::ST_FETCH;
            end
         end

         bdbag_pkg::ST_FETCH: begin
            if (empty) begin
               front_in = '0;
               back_in  = '0;
               state_in = bdbag_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = bdbag_pkg::ST_FRONT;
            end
         end

         bdbag_pkg::ST_FRONT: begin
            front_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, count_ff - 1'b1);
            state_in = bdbag_pkg::ST_BACK;
         end

         bdbag_pkg::ST_BACK: begin
            back_in  = rd_data;
            state_in = bdbag_pkg::ST_DONE;
         end

         bdbag_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({status_ff, found_ff, empty, count_ff,
                                      back_ff, front_ff});
               state_in     = bdbag_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bdbag_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bdbag_ram.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on bdbag_pkg for the default data width.
`timescale 1ns / 1ps

module bdbag_ram #(
   parameter int DEPTH  = bdbag_pkg::CAPACITY_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = bdbag_pkg::DATA_W
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] entry_store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
